### sv/mmt_pkg.sv
package mmt_pkg;

  localparam int unsigned VALUE_RANGE = 1024;
  localparam int unsigned VALUE_W     = $clog2(VALUE_RANGE);
  localparam int unsigned MEX_W       = VALUE_W + 1;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned BIT_W       = $clog2(WORD_BITS);
  localparam int unsigned MAP_WORDS   = VALUE_RANGE / WORD_BITS;
  localparam int unsigned WORD_IDX_W  = $clog2(MAP_WORDS);

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_REPLACE = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_RANGE  = 2'd1;
  localparam logic [1:0] STATUS_ABSENT = 2'd2;
  localparam logic [1:0] STATUS_SAT    = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
    logic signed [31:0] old_value;
  } item_t;

  typedef struct packed {
    logic [MEX_W-1:0] mex;
    logic [1:0]       status;
  } result_t;

endpackage

### sv/multiset_mex_tracker.sv
// Multiset mex tracker.
// An item on the item channel (valid/ready) adds a value, removes a value, or
// replaces old_value by value. Each item gives exactly one result on the
// result channel (valid/ready): the mex after the update and a status code.
// The block handles one item at a time and is not ready while an item is in
// flight. An add or remove passes through the read, update and done states;
// a replace runs read and update for old_value, then again for value. An
// unused operation goes straight to done, and an out-of-range value skips its
// update state. An add that fills the current mex then scans the presence
// bitmap one 64-bit word per cycle. The single read port of the bitmap memory
// sets that scan rate. The block is ready for the next item in the same cycle
// that the result comes out.
// The result sits in an output register, so a new item is accepted while the
// previous result waits; a finished item then holds until the receiver takes
// the pending result.
// After reset the block sweeps the count memory and the bitmap to zero, one
// count entry per cycle, and accepts no item during the sweep. The mex starts
// at zero.
module multiset_mex_tracker #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  mmt_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output mmt_pkg::result_t result
);

  localparam int unsigned VW  = mmt_pkg::VALUE_W;
  localparam int unsigned BW  = mmt_pkg::BIT_W;
  localparam int unsigned WIW = mmt_pkg::WORD_IDX_W;
  localparam int unsigned WB  = mmt_pkg::WORD_BITS;
  localparam int unsigned MW  = mmt_pkg::MEX_W;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
  localparam logic [WIW-1:0] LAST_WORD = WIW'(mmt_pkg::MAP_WORDS - 1);
  localparam logic [VW-1:0] LAST_ADDR = VW'(mmt_pkg::VALUE_RANGE - 1);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_READ    = 3'd2;
  localparam logic [2:0] ST_UPDATE  = 3'd3;
  localparam logic [2:0] ST_SCAN_RD = 3'd4;
  localparam logic [2:0] ST_SCAN    = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  function automatic logic [BW-1:0] first_one(input logic [WB-1:0] w);
    logic [BW-1:0] pos;
    pos = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = BW'(i);
      end
    end
    return pos;
  endfunction

  logic [2:0]             state, state_next;
  logic [VW-1:0]          clr_addr, clr_addr_next;
  logic [MW-1:0]          mex, mex_next;
  logic [1:0]             st, st_next;
  logic [31:0]            cur_val, cur_val_next;
  logic [31:0]            add_val, add_val_next;
  logic                   pend_add, pend_add_next;
  logic                   is_add, is_add_next;
  logic [WIW-1:0]         scan_word, scan_word_next;

  logic [COUNT_WIDTH-1:0] counts [mmt_pkg::VALUE_RANGE];
  logic [WB-1:0]          pmap [mmt_pkg::MAP_WORDS];
  logic [COUNT_WIDTH-1:0] count_rd;
  logic [WB-1:0]          map_rd;

  logic                   cnt_we;
  logic [VW-1:0]          cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic                   map_we;
  logic [WIW-1:0]         map_waddr;
  logic [WB-1:0]          map_wdata;
  logic [WIW-1:0]         map_raddr;

  logic [VW-1:0]          val_idx;
  logic                   in_range;
  logic [WB-1:0]          free_bits;
  logic                   half_done;
  logic [1:0]             half_status;
  logic                   load_result;

  assign val_idx    = cur_val[VW-1:0];
  assign in_range   = (cur_val[31:VW] == '0);
  assign free_bits  = ~map_rd & ({WB{1'b1}} << mex[BW-1:0]);
  assign item_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    mex_next       = mex;
    st_next        = st;
    cur_val_next   = cur_val;
    add_val_next   = add_val;
    pend_add_next  = pend_add;
    is_add_next    = is_add;
    scan_word_next = scan_word;
    cnt_we         = 1'b0;
    cnt_waddr      = val_idx;
    cnt_wdata      = count_rd;
    map_we         = 1'b0;
    map_waddr      = val_idx[VW-1:BW];
    map_wdata      = map_rd;
    map_raddr      = val_idx[VW-1:BW];
    half_done      = 1'b0;
    half_status    = mmt_pkg::STATUS_OK;
    load_result    = 1'b0;

    case (state)
      ST_CLEAR: begin
        cnt_we        = 1'b1;
        cnt_waddr     = clr_addr;
        cnt_wdata     = '0;
        map_we        = 1'b1;
        map_waddr     = clr_addr[VW-1:BW];
        map_wdata     = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          st_next       = mmt_pkg::STATUS_OK;
          pend_add_next = 1'b0;
          add_val_next  = item.value;
          case (item.operation)
            mmt_pkg::OP_ADD: begin
              cur_val_next = item.value;
              is_add_next  = 1'b1;
              state_next   = ST_READ;
            end
            mmt_pkg::OP_REMOVE: begin
              cur_val_next = item.value;
              is_add_next  = 1'b0;
              state_next   = ST_READ;
            end
            mmt_pkg::OP_REPLACE: begin
              cur_val_next  = item.old_value;
              is_add_next   = 1'b0;
              pend_add_next = 1'b1;
              state_next    = ST_READ;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        if (!in_range) begin
          half_done   = 1'b1;
          half_status = mmt_pkg::STATUS_RANGE;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        half_done = 1'b1;
        if (is_add) begin
          if (count_rd == COUNT_MAX) begin
            half_status = mmt_pkg::STATUS_SAT;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = count_rd + 1'b1;
            if (count_rd == '0) begin
              map_we                  = 1'b1;
              map_wdata[val_idx[BW-1:0]] = 1'b1;
              if ({1'b0, val_idx} == mex) begin
                half_done      = 1'b0;
                scan_word_next = val_idx[VW-1:BW];
                state_next     = ST_SCAN_RD;
              end
            end
          end
        end else begin
          if (count_rd == '0) begin
            half_status = mmt_pkg::STATUS_ABSENT;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = count_rd - 1'b1;
            if (count_rd == COUNT_ONE) begin
              map_we                  = 1'b1;
              map_wdata[val_idx[BW-1:0]] = 1'b0;
              if ({1'b0, val_idx} < mex) begin
                mex_next = {1'b0, val_idx};
              end
            end
          end
        end
      end
      ST_SCAN_RD: begin
        map_raddr  = scan_word;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        map_raddr = scan_word + 1'b1;
        if (free_bits != '0) begin
          mex_next   = {1'b0, scan_word, first_one(free_bits)};
          state_next = ST_DONE;
        end else if (scan_word == LAST_WORD) begin
          mex_next   = MW'(mmt_pkg::VALUE_RANGE);
          state_next = ST_DONE;
        end else begin
          mex_next       = {1'b0, scan_word + 1'b1, BW'(0)};
          scan_word_next = scan_word + 1'b1;
        end
      end
      ST_DONE: begin
        if (!result_valid || result_ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // The first non-zero status of the two halves of a replace wins.
    if (half_done) begin
      if (st == mmt_pkg::STATUS_OK) begin
        st_next = half_status;
      end
      if (pend_add) begin
        pend_add_next = 1'b0;
        is_add_next   = 1'b1;
        cur_val_next  = add_val;
        state_next    = ST_READ;
      end else begin
        state_next = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      counts[cnt_waddr] <= cnt_wdata;
    end
    count_rd <= counts[val_idx];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      pmap[map_waddr] <= map_wdata;
    end
    map_rd <= pmap[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      mex          <= '0;
      result_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      mex      <= mex_next;
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    st        <= st_next;
    cur_val   <= cur_val_next;
    add_val   <= add_val_next;
    pend_add  <= pend_add_next;
    is_add    <= is_add_next;
    scan_word <= scan_word_next;
    if (load_result) begin
      result.mex    <= mex;
      result.status <= st;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item accepted while previous item still in flight");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the completion state");

  a_scan_tracks_mex: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ((mex[VW-1:BW] == scan_word) && !mex[MW-1]))
    else $error("bitmap scan word does not match the mex");
`endif

endmodule
